FILE: hw/rtl/tmt_pkg.sv
// Shared types and constants for the template markup tokenizer.
// Holds the transfer structs, the token kind codes and the offset saturation helper.
// No dependencies.
package tmt_pkg;

  localparam int unsigned MAX_TEMPLATE_BYTES = 65536;
  // Position must be able to hold MAX_TEMPLATE_BYTES itself (it saturates there).
  localparam int unsigned POS_W = $clog2(MAX_TEMPLATE_BYTES + 1);

  typedef logic [POS_W-1:0] pos_t;

  typedef enum logic [3:0] {
    K_TEXT       = 4'd0,
    K_BSTART     = 4'd1,
    K_BEND       = 4'd2,
    K_VAR        = 4'd3,
    K_MODIF      = 4'd4,
    K_IF         = 4'd5,
    K_ELSE       = 4'd6,
    K_ENDIF      = 4'd7,
    K_FOREACH    = 4'd8,
    K_ENDFOREACH = 4'd9,
    K_AS         = 4'd10,
    K_ERROR      = 4'd11,
    K_EOF        = 4'd12
  } tok_kind_t;

  typedef enum logic {
    OP_CHAR = 1'b0,
    OP_END  = 1'b1
  } op_t;

  typedef struct packed {
    logic       operation;
    logic [7:0] char_byte;
  } in_item_t;

  typedef struct packed {
    tok_kind_t   token_kind;
    logic [15:0] token_start;
    logic [15:0] token_length;
    logic        last_of_run;
  } tok_t;

  // Results of one processed item: up to two tokens, in order.
  typedef struct packed {
    logic [1:0]     count;
    tok_t [1:0]     tok;
  } lex_res_t;

  function automatic logic [15:0] sat16(pos_t v);
    logic [POS_W+15:0] w;
    w = {{16{1'b0}}, v};
    if (w > (POS_W+16)'(65535)) begin
      return 16'hFFFF;
    end
    return w[15:0];
  endfunction

  function automatic tok_t mk_tok(tok_kind_t kind, pos_t start, pos_t len);
    tok_t t;
    t.token_kind   = kind;
    t.token_start  = sat16(start);
    t.token_length = sat16(len);
    t.last_of_run  = 1'b0;
    return t;
  endfunction

endpackage

FILE: hw/rtl/tmt_lexer.sv
// Lexer state and single-pass next-state logic of the template markup tokenizer.
// Produces up to two tokens per processed item. Depends on tmt_pkg.
module tmt_lexer (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  tmt_pkg::in_item_t item,
  output tmt_pkg::lex_res_t res
);
  import tmt_pkg::*;

  typedef enum logic [2:0] {
    M_TEXT, M_INSIDE, M_IDENT, M_VARBEG, M_VAR, M_MODBEG, M_MOD, M_ERROR
  } mode_t;

  localparam int unsigned NKW = 6;
  localparam logic [3:0] KW_LEN [NKW] = '{4'd2, 4'd4, 4'd5, 4'd7, 4'd10, 4'd2};
  localparam logic [7:0] KW_TEXT [NKW][16] = '{
    '{0:"i", 1:"f", default:8'h00},
    '{0:"e", 1:"l", 2:"s", 3:"e", default:8'h00},
    '{0:"e", 1:"n", 2:"d", 3:"i", 4:"f", default:8'h00},
    '{0:"f", 1:"o", 2:"r", 3:"e", 4:"a", 5:"c", 6:"h", default:8'h00},
    '{0:"e", 1:"n", 2:"d", 3:"f", 4:"o", 5:"r", 6:"e", 7:"a", 8:"c", 9:"h",
      default:8'h00},
    '{0:"a", 1:"s", default:8'h00}
  };
  localparam tok_kind_t KW_KIND [NKW] = '{K_IF, K_ELSE, K_ENDIF, K_FOREACH, K_ENDFOREACH, K_AS};
  localparam pos_t MAX_POS = POS_W'(MAX_TEMPLATE_BYTES);

  function automatic logic is_letter(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_alnum(logic [7:0] c);
    return is_letter(c) || (c >= "0" && c <= "9");
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return c == " " || c == 8'h09 || c == 8'h0D || c == 8'h0A;
  endfunction

  // Drop keywords whose letter at this identifier length differs.
  function automatic logic [NKW-1:0] kw_filter(logic [NKW-1:0] cand, logic [3:0] idl,
                                               logic [7:0] c);
    logic [NKW-1:0] f;
    for (int k = 0; k < NKW; k++) begin
      f[k] = cand[k] && (idl < KW_LEN[k]) && (KW_TEXT[k][idl] == c);
    end
    return f;
  endfunction

  mode_t          mode_r, mode_nxt;
  pos_t           pos_r, pos_nxt;
  pos_t           cs_r, cs_nxt;
  logic [NKW-1:0] cand_r, cand_nxt;
  logic [3:0]     idl_r, idl_nxt;

  logic [7:0] c;
  pos_t       p;
  pos_t       run_len;
  logic       at_max;
  logic       reexam;
  logic       kw_hit;
  tok_kind_t  kw_kind;
  logic [1:0] n_tok;

  assign c       = item.char_byte;
  assign p       = pos_r;
  assign at_max  = (pos_r == MAX_POS);
  assign run_len = (p > cs_r) ? p - cs_r : '0;

  always_comb begin
    kw_hit  = 1'b0;
    kw_kind = K_IF;
    for (int k = 0; k < NKW; k++) begin
      if (!kw_hit && cand_r[k] && idl_r == KW_LEN[k]) begin
        kw_hit  = 1'b1;
        kw_kind = KW_KIND[k];
      end
    end
  end

  always_comb begin
    mode_nxt = mode_r;
    pos_nxt  = pos_r;
    cs_nxt   = cs_r;
    cand_nxt = cand_r;
    idl_nxt  = idl_r;
    reexam   = 1'b0;
    n_tok    = 2'd0;
    res      = '0;

    if (op_t'(item.operation) == OP_END) begin
      if (mode_r == M_TEXT) begin
        if (cs_r != p) begin
          res.tok[n_tok[0]] = mk_tok(K_TEXT, cs_r, run_len);
          n_tok = n_tok + 2'd1;
        end
        res.tok[n_tok[0]] = mk_tok(K_EOF, p, '0);
        n_tok  = n_tok + 2'd1;
        cs_nxt = p;
      end else begin
        res.tok[n_tok[0]] = mk_tok(K_ERROR, p, '0);
        n_tok    = n_tok + 2'd1;
        mode_nxt = M_ERROR;
      end
    end else begin
      if (mode_r == M_ERROR) begin
        // sticky: nothing further
      end else if (at_max) begin
        res.tok[n_tok[0]] = mk_tok(K_ERROR, p, '0);
        n_tok    = n_tok + 2'd1;
        mode_nxt = M_ERROR;
      end else begin
        case (mode_r)
          M_TEXT: begin
            if (c == "{") begin
              if (cs_r != p) begin
                res.tok[n_tok[0]] = mk_tok(K_TEXT, cs_r, run_len);
                n_tok = n_tok + 2'd1;
              end
              res.tok[n_tok[0]] = mk_tok(K_BSTART, p, '0);
              n_tok    = n_tok + 2'd1;
              mode_nxt = M_INSIDE;
            end
          end
          M_INSIDE: reexam = 1'b1;
          M_IDENT: begin
            if (is_alnum(c)) begin
              cand_nxt = kw_filter(cand_r, idl_r, c);
              idl_nxt  = (idl_r == 4'd15) ? idl_r : idl_r + 4'd1;
            end else if ((is_space(c) || c == "}") && kw_hit) begin
              res.tok[n_tok[0]] = mk_tok(kw_kind, cs_r, '0);
              n_tok    = n_tok + 2'd1;
              mode_nxt = M_INSIDE;
              reexam   = 1'b1;
            end else begin
              res.tok[n_tok[0]] = mk_tok(K_ERROR, p, '0);
              n_tok    = n_tok + 2'd1;
              mode_nxt = M_ERROR;
            end
          end
          M_VARBEG: begin
            if (is_letter(c)) begin
              mode_nxt = M_VAR;
            end else begin
              res.tok[n_tok[0]] = mk_tok(K_ERROR, p, '0);
              n_tok    = n_tok + 2'd1;
              mode_nxt = M_ERROR;
            end
          end
          M_VAR: begin
            if (is_alnum(c)) begin
              // hold
            end else if (c == ".") begin
              mode_nxt = M_VARBEG;
            end else begin
              res.tok[n_tok[0]] = mk_tok(K_VAR, cs_r, run_len);
              n_tok    = n_tok + 2'd1;
              mode_nxt = M_INSIDE;
              reexam   = 1'b1;
            end
          end
          M_MODBEG: begin
            if (is_letter(c)) begin
              cs_nxt   = p;
              mode_nxt = M_MOD;
            end else begin
              res.tok[n_tok[0]] = mk_tok(K_ERROR, p, '0);
              n_tok    = n_tok + 2'd1;
              mode_nxt = M_ERROR;
            end
          end
          M_MOD: begin
            if (!is_alnum(c)) begin
              res.tok[n_tok[0]] = mk_tok(K_MODIF, cs_r, run_len);
              n_tok    = n_tok + 2'd1;
              mode_nxt = M_INSIDE;
              reexam   = 1'b1;
            end
          end
          default: ;
        endcase

        // Block content: also the second look at a byte that ended an item.
        if (reexam) begin
          if (c == "$") begin
            mode_nxt = M_VARBEG;
            cs_nxt   = p + POS_W'(1);
          end else if (is_letter(c)) begin
            mode_nxt = M_IDENT;
            cs_nxt   = p;
            cand_nxt = kw_filter({NKW{1'b1}}, 4'd0, c);
            idl_nxt  = 4'd1;
          end else if (is_space(c)) begin
            // skip
          end else if (c == "|") begin
            mode_nxt = M_MODBEG;
          end else if (c == "}") begin
            res.tok[n_tok[0]] = mk_tok(K_BEND, p, '0);
            n_tok    = n_tok + 2'd1;
            mode_nxt = M_TEXT;
            cs_nxt   = p + POS_W'(1);
          end else begin
            res.tok[n_tok[0]] = mk_tok(K_ERROR, p, '0);
            n_tok    = n_tok + 2'd1;
            mode_nxt = M_ERROR;
          end
        end
      end
      if (!at_max) begin
        pos_nxt = pos_r + POS_W'(1);
      end
    end

    if (n_tok == 2'd1) begin
      res.tok[0].last_of_run = 1'b1;
    end else if (n_tok == 2'd2) begin
      res.tok[1].last_of_run = 1'b1;
    end
    res.count = n_tok;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_TEXT;
      pos_r  <= '0;
      cs_r   <= '0;
      cand_r <= '0;
      idl_r  <= '0;
    end else if (step) begin
      mode_r <= mode_nxt;
      pos_r  <= pos_nxt;
      cs_r   <= cs_nxt;
      cand_r <= cand_nxt;
      idl_r  <= idl_nxt;
    end
  end

  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n) pos_r <= MAX_POS)
    else $error("byte position beyond maximum");
  a_cs_behind: assert property (@(posedge clk) disable iff (!rst_n) cs_r <= pos_r)
    else $error("content start ahead of byte position");
  a_err_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (step && mode_r == M_ERROR && op_t'(item.operation) == OP_CHAR) |-> res.count == 2'd0)
    else $error("token produced in error mode");

endmodule

FILE: hw/rtl/tmt_out_buf.sv
// Two-slot result holder: takes both tokens of one item at once, hands them out in order.
// Depends on tmt_pkg.
module tmt_out_buf (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  tmt_pkg::lex_res_t res,
  output logic              can_take,
  output logic              out_valid,
  input  logic              out_ready,
  output tmt_pkg::tok_t     out_data
);
  import tmt_pkg::*;

  tok_t       slot0_r, slot1_r;
  logic [1:0] cnt_r;
  logic       pop;

  assign out_valid = (cnt_r != 2'd0);
  assign out_data  = slot0_r;
  assign pop       = out_valid && out_ready;
  assign can_take  = (cnt_r == 2'd0) || (cnt_r == 2'd1 && out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else if (push) begin
      cnt_r <= res.count;
    end else if (pop) begin
      cnt_r <= cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot0_r <= res.tok[0];
      slot1_r <= res.tok[1];
    end else if (pop) begin
      slot0_r <= slot1_r;
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n) cnt_r != 2'd3)
    else $error("result count out of range");
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (cnt_r == 2'd0 || (cnt_r == 2'd1 && out_ready)))
    else $error("results loaded over pending tokens");
  a_pair_last: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 2'd2 |-> (slot1_r.last_of_run && !slot0_r.last_of_run))
    else $error("last-of-run marking wrong in token pair");

endmodule

FILE: hw/rtl/template_markup_tokenizer_core.sv
// Top level of the template markup tokenizer: input register, lexer and result holder.
// Depends on tmt_pkg, tmt_lexer and tmt_out_buf.
//
// Template bytes enter one transfer at a time on the in_ channel; the end-of-template
// operation closes the stream. Each item is registered, then tokenised in a single
// pass of short logic and its tokens (none, one or two) land in a two-slot result
// holder. A new item is taken in every cycle while results keep draining and no
// more than one token waits; an item with two tokens holds the next one back, since
// the out_ channel moves one token per cycle. Tokens pass the input register, then a
// holder slot. Errors are sticky until reset; offsets and lengths saturate at 65535.
module template_markup_tokenizer_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  tmt_pkg::in_item_t in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output tmt_pkg::tok_t     out_data
);
  import tmt_pkg::*;

  logic     in_v_r;
  in_item_t in_d_r;
  logic     can_take;
  logic     fire;
  lex_res_t res;

  // Process the registered item once the result holder can take its tokens.
  assign fire     = in_v_r && can_take;
  // Accept a fresh transfer whenever the input register is empty or drains now.
  assign in_ready = !in_v_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ready) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_d_r <= in_data;
    end
  end

  tmt_lexer u_lexer (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (fire),
    .item  (in_d_r),
    .res   (res)
  );

  tmt_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (fire),
    .res       (res),
    .can_take  (can_take),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
